>>> hw/rtl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types and constants for the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

    localparam int MAX_SIZE_DIGITS = 8;
    localparam int DIGIT_W         = 4;
    localparam int COUNT_W         = 32;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [3:0] HEX_TEN   = 4'd10;

    typedef enum logic [2:0] {
        PH_SIZE = 3'd0,
        PH_CR   = 3'd1,
        PH_DATA = 3'd2,
        PH_DONE = 3'd3,
        PH_HALT = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_DONE    = 3'd1,
        EV_BADCHAR = 3'd2,
        EV_TOOLONG = 3'd3,
        EV_EARLY   = 3'd4
    } t_event;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        t_event     event_res;
    } t_out_item;

    // Classified byte as handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } t_cls_item;

endpackage

`default_nettype wire

>>> hw/rtl/chunked_body_decoder.sv
// A result is registered in the queue and then in the output register before it is offered.
// Throughput: one byte per cycle while results are taken; the parser state update in the back
// end closes its loop for every byte and the output register refills on take.
// A four-entry queue separates the classifier front end from the parser.
// Reset: synchronous active-low i_rst_n clears the queue, the parser (size line
// state, zero count) and the output valid.
// ----------------------------------------------------------------------------
// chunked_body_decoder
// Decodes an HTTP chunked body byte stream into payload bytes and events.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_body_decoder #(
    parameter int MAX_SIZE_DIGITS = cbd_pkg::MAX_SIZE_DIGITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire cbd_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output cbd_pkg::t_out_item       o_out_res
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    cbd_pkg::t_cls_item q_wdata;
    cbd_pkg::t_cls_item q_rdata;

    cbd_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_wdata  (q_wdata)
    );

    cbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    cbd_back #(
        .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_rdata   (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

endmodule

`default_nettype wire

>>> hw/rtl/cbd_front.sv
// ----------------------------------------------------------------------------
// cbd_front
// Input handshake and byte classification (hex digit, CR, LF).
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_front (
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire cbd_pkg::t_in_item  i_in_data,
    input  wire logic               i_q_full,
    output logic                    o_q_push,
    output cbd_pkg::t_cls_item      o_q_wdata
);

    logic [7:0] b;

    assign b          = i_in_data.data_byte;
    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    always_comb begin
        o_q_wdata            = '0;
        o_q_wdata.data_byte  = b;
        o_q_wdata.first_byte = i_in_data.first_byte;
        o_q_wdata.last_byte  = i_in_data.last_byte;
        o_q_wdata.is_cr      = (b == cbd_pkg::CH_CR);
        o_q_wdata.is_lf      = (b == cbd_pkg::CH_LF);
        if (b >= cbd_pkg::CH_0 && b <= cbd_pkg::CH_9) begin
            o_q_wdata.is_hex  = 1'b1;
            o_q_wdata.hex_val = 4'(b - cbd_pkg::CH_0);
        end else if (b >= cbd_pkg::CH_UP_A && b <= cbd_pkg::CH_UP_F) begin
            o_q_wdata.is_hex  = 1'b1;
            o_q_wdata.hex_val = 4'(b - cbd_pkg::CH_UP_A) + cbd_pkg::HEX_TEN;
        end else if (b >= cbd_pkg::CH_LO_A && b <= cbd_pkg::CH_LO_F) begin
            o_q_wdata.is_hex  = 1'b1;
            o_q_wdata.hex_val = 4'(b - cbd_pkg::CH_LO_A) + cbd_pkg::HEX_TEN;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cbd_fifo.sv
// ----------------------------------------------------------------------------
// cbd_fifo
// Short queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire cbd_pkg::t_cls_item  i_wdata,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_valid,
    output cbd_pkg::t_cls_item       o_rdata
);

    cbd_pkg::t_cls_item           r_mem [cbd_pkg::Q_DEPTH];
    logic [cbd_pkg::Q_AW-1:0]     r_wptr, n_wptr;
    logic [cbd_pkg::Q_AW-1:0]     r_rptr, n_rptr;
    logic [cbd_pkg::Q_CW-1:0]     r_cnt, n_cnt;

    assign o_full  = (r_cnt == cbd_pkg::Q_CW'(cbd_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cbd_back.sv
// ----------------------------------------------------------------------------
// cbd_back
// Chunk parser state machine and registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_back #(
    parameter int MAX_SIZE_DIGITS = cbd_pkg::MAX_SIZE_DIGITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_q_valid,
    input  wire cbd_pkg::t_cls_item  i_q_rdata,
    output logic                     o_q_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output cbd_pkg::t_out_item       o_out_res
);

    localparam logic [cbd_pkg::DIGIT_W-1:0] MAX_DIG = cbd_pkg::DIGIT_W'(MAX_SIZE_DIGITS);

    cbd_pkg::t_phase                r_phase, n_phase, cur_phase;
    logic [cbd_pkg::COUNT_W-1:0]    r_cnt, n_cnt, cur_cnt, cnt_dec;
    logic [cbd_pkg::DIGIT_W-1:0]    r_dig, n_dig, cur_dig;
    logic                           r_out_valid;
    cbd_pkg::t_out_item             r_out;
    cbd_pkg::t_out_item             res;
    logic                           res_valid;

    assign o_q_pop     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;
    assign cnt_dec     = cur_cnt - 1'b1;

    always_comb begin
        cur_phase = r_phase;
        cur_cnt   = r_cnt;
        cur_dig   = r_dig;
        // restart parser ahead of the first byte of a message
        if (i_q_rdata.first_byte) begin
            cur_phase = cbd_pkg::PH_SIZE;
            cur_cnt   = '0;
            cur_dig   = '0;
        end

        n_phase       = cur_phase;
        n_cnt         = cur_cnt;
        n_dig         = cur_dig;
        res           = '0;
        res.event_res = cbd_pkg::EV_NONE;

        case (cur_phase)
            cbd_pkg::PH_SIZE: begin
                if (i_q_rdata.is_cr) begin
                    n_phase = cbd_pkg::PH_CR;
                end else if (i_q_rdata.is_hex) begin
                    if (cur_dig >= MAX_DIG) begin
                        res.event_res = cbd_pkg::EV_TOOLONG;
                        n_phase       = cbd_pkg::PH_HALT;
                    end else begin
                        n_cnt = {cur_cnt[cbd_pkg::COUNT_W-5:0], i_q_rdata.hex_val};
                        n_dig = cur_dig + 1'b1;
                    end
                end else begin
                    res.event_res = cbd_pkg::EV_BADCHAR;
                    n_phase       = cbd_pkg::PH_HALT;
                end
            end
            cbd_pkg::PH_CR: begin
                if (!i_q_rdata.is_lf) begin
                    res.event_res = cbd_pkg::EV_BADCHAR;
                    n_phase       = cbd_pkg::PH_HALT;
                end else if (cur_dig == '0) begin
                    // skip empty line
                    n_phase = cbd_pkg::PH_SIZE;
                end else if (cur_cnt == '0) begin
                    res.event_res = cbd_pkg::EV_DONE;
                    n_phase       = cbd_pkg::PH_DONE;
                    n_dig         = '0;
                end else begin
                    n_phase = cbd_pkg::PH_DATA;
                    n_dig   = '0;
                end
            end
            cbd_pkg::PH_DATA: begin
                res.has_byte = 1'b1;
                res.out_byte = i_q_rdata.data_byte;
                n_cnt        = cnt_dec;
                if (cnt_dec == '0) begin
                    n_phase = cbd_pkg::PH_SIZE;
                end
            end
            default: begin
                // done or halted: drop bytes
            end
        endcase

        if (i_q_rdata.last_byte && res.event_res == cbd_pkg::EV_NONE &&
            (n_phase == cbd_pkg::PH_SIZE || n_phase == cbd_pkg::PH_CR ||
             n_phase == cbd_pkg::PH_DATA)) begin
            res.event_res = cbd_pkg::EV_EARLY;
            n_phase       = cbd_pkg::PH_HALT;
        end

        res_valid = res.has_byte || (res.event_res != cbd_pkg::EV_NONE);

        // hold state unless a transaction is consumed
        if (!o_q_pop) begin
            n_phase = r_phase;
            n_cnt   = r_cnt;
            n_dig   = r_dig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= cbd_pkg::PH_SIZE;
            r_cnt       <= '0;
            r_dig       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_dig   <= n_dig;
            if (o_q_pop) begin
                r_out_valid <= res_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

>>> bench/chunked_body_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_body_decoder_tb
// Feeds chunked bodies byte by byte (well-formed messages with random sizes
// and data, plus truncated, malformed and oversized size lines), predicts the
// payload bytes and events in step with each accepted transaction and checks
// every result transaction in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module chunked_body_decoder_tb;

    typedef enum int {
        MSG_CLEAN,
        MSG_CUT,
        MSG_BADCHAR,
        MSG_LONECR,
        MSG_LONG
    } t_msg_kind;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    cbd_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    cbd_pkg::t_out_item out_res;

    int        cycles    = 0;
    logic      calm;

    cbd_pkg::t_in_item  pending_bytes[$];
    cbd_pkg::t_out_item expected_results[$];
    logic [7:0] msg[$];

    // Parser state as predicted
    cbd_pkg::t_phase prs_phase  = cbd_pkg::PH_SIZE;
    logic [31:0]     prs_count  = '0;
    logic [3:0]      prs_digits = '0;

    int n_err     = 0;
    int n_bytes   = 0;
    int n_msgs    = 0;
    int n_payload = 0;
    int n_done    = 0;
    int n_fault   = 0;

    chunked_body_decoder u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_res   (out_res)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // No idling on either side inside this window
    assign calm = (cycles >= 400) && (cycles < 800);

    function automatic bit hex_digit(input logic [7:0] b, output logic [3:0] v);
        v = '0;
        if (b >= cbd_pkg::CH_0 && b <= cbd_pkg::CH_9) begin
            v = 4'(b - cbd_pkg::CH_0);
            return 1'b1;
        end
        if (b >= cbd_pkg::CH_UP_A && b <= cbd_pkg::CH_UP_F) begin
            v = 4'(b - cbd_pkg::CH_UP_A) + cbd_pkg::HEX_TEN;
            return 1'b1;
        end
        if (b >= cbd_pkg::CH_LO_A && b <= cbd_pkg::CH_LO_F) begin
            v = 4'(b - cbd_pkg::CH_LO_A) + cbd_pkg::HEX_TEN;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < cbd_pkg::HEX_TEN) return cbd_pkg::CH_0 + 8'(v);
        return (upper ? cbd_pkg::CH_UP_A : cbd_pkg::CH_LO_A) + 8'(v - cbd_pkg::HEX_TEN);
    endfunction

    // Advance the predicted parser by one byte; return 1 when a result is due
    function automatic bit decode_byte(input cbd_pkg::t_in_item it,
                                       output cbd_pkg::t_out_item res);
        logic [3:0]      v;
        bit              has;
        cbd_pkg::t_event ev;
        has = 1'b0;
        ev  = cbd_pkg::EV_NONE;
        if (it.first_byte) begin
            prs_phase  = cbd_pkg::PH_SIZE;
            prs_count  = '0;
            prs_digits = '0;
        end
        case (prs_phase)
            cbd_pkg::PH_SIZE: begin
                if (it.data_byte == cbd_pkg::CH_CR) begin
                    prs_phase = cbd_pkg::PH_CR;
                end else if (hex_digit(it.data_byte, v)) begin
                    if (prs_digits >= cbd_pkg::MAX_SIZE_DIGITS) begin
                        ev        = cbd_pkg::EV_TOOLONG;
                        prs_phase = cbd_pkg::PH_HALT;
                    end else begin
                        prs_count  = {prs_count[27:0], v};
                        prs_digits = prs_digits + 4'd1;
                    end
                end else begin
                    ev        = cbd_pkg::EV_BADCHAR;
                    prs_phase = cbd_pkg::PH_HALT;
                end
            end
            cbd_pkg::PH_CR: begin
                if (it.data_byte != cbd_pkg::CH_LF) begin
                    ev        = cbd_pkg::EV_BADCHAR;
                    prs_phase = cbd_pkg::PH_HALT;
                end else if (prs_digits == '0) begin
                    prs_phase = cbd_pkg::PH_SIZE;
                end else if (prs_count == '0) begin
                    ev         = cbd_pkg::EV_DONE;
                    prs_phase  = cbd_pkg::PH_DONE;
                    prs_digits = '0;
                end else begin
                    prs_phase  = cbd_pkg::PH_DATA;
                    prs_digits = '0;
                end
            end
            cbd_pkg::PH_DATA: begin
                has       = 1'b1;
                prs_count = prs_count - 32'd1;
                if (prs_count == '0) prs_phase = cbd_pkg::PH_SIZE;
            end
            default: ;
        endcase
        if (it.last_byte && ev == cbd_pkg::EV_NONE &&
            (prs_phase == cbd_pkg::PH_SIZE || prs_phase == cbd_pkg::PH_CR ||
             prs_phase == cbd_pkg::PH_DATA)) begin
            ev        = cbd_pkg::EV_EARLY;
            prs_phase = cbd_pkg::PH_HALT;
        end
        res.has_byte  = has;
        res.out_byte  = has ? it.data_byte : 8'h00;
        res.event_res = ev;
        return has || (ev != cbd_pkg::EV_NONE);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        n_err++;
    endtask

    task automatic put_crlf();
        msg.push_back(cbd_pkg::CH_CR);
        msg.push_back(cbd_pkg::CH_LF);
    endtask

    // Hex size with random case and optional leading zeros
    task automatic put_size(input logic [31:0] size);
        int ndig;
        int width;
        ndig = 1;
        for (int i = 1; i < 8; i++) if (size[4*i +: 4] != 4'h0) ndig = i + 1;
        width = ($urandom_range(3) == 0) ? $urandom_range(8, ndig) : ndig;
        for (int i = width - 1; i >= 0; i--)
            msg.push_back(hex_char(size[4*i +: 4], $urandom_range(1)));
    endtask

    task automatic send_msg(input int last_at);
        cbd_pkg::t_in_item it;
        for (int i = 0; i < msg.size(); i++) begin
            it.data_byte  = msg[i];
            it.first_byte = (i == 0);
            it.last_byte  = (i == last_at);
            pending_bytes.push_back(it);
        end
        n_msgs++;
    endtask

    task automatic build_message(output int useful);
        t_msg_kind   kind;
        int          roll;
        int          nchunks;
        int          brk_at;
        int          last_at;
        int          k;
        bit          stop;
        bit          wide;
        logic [31:0] size;
        logic [7:0]  b;
        logic [3:0]  dv;
        msg.delete();
        roll = $urandom_range(99);
        kind = roll < 62 ? MSG_CLEAN : roll < 77 ? MSG_CUT :
               roll < 85 ? MSG_BADCHAR : roll < 92 ? MSG_LONECR : MSG_LONG;
        nchunks = $urandom_range(3);
        brk_at  = $urandom_range(nchunks);
        stop    = 1'b0;
        wide    = 1'b0;
        for (int c = 0; c <= nchunks && !stop; c++) begin
            if ($urandom_range(9) == 0) put_crlf();
            if (kind >= MSG_BADCHAR && c == brk_at) begin
                stop = 1'b1;
                if (kind == MSG_LONG) begin
                    repeat (cbd_pkg::MAX_SIZE_DIGITS + 1 + $urandom_range(1))
                        msg.push_back(hex_char(4'($urandom), $urandom_range(1)));
                end else begin
                    repeat ($urandom_range(2))
                        msg.push_back(hex_char(4'($urandom), $urandom_range(1)));
                    if (kind == MSG_BADCHAR) begin
                        do b = 8'($urandom); while (b == cbd_pkg::CH_CR || hex_digit(b, dv));
                        msg.push_back(b);
                    end else begin
                        do b = 8'($urandom); while (b == cbd_pkg::CH_LF);
                        msg.push_back(cbd_pkg::CH_CR);
                        msg.push_back(b);
                    end
                end
            end else if (c == nchunks) begin
                put_size('0);
                put_crlf();
            end else begin
                roll = $urandom_range(99);
                size = roll < 85 ? 32'($urandom_range(1, 8)) :
                       roll < 95 ? 32'($urandom_range(9, 40)) : ($urandom | 32'h100);
                put_size(size);
                put_crlf();
                if (size > 32'd64) begin
                    // Too big to send whole: pass a few bytes and end the input
                    wide = 1'b1;
                    stop = 1'b1;
                    repeat ($urandom_range(1, 5)) msg.push_back(8'($urandom));
                end else begin
                    repeat (size) msg.push_back(8'($urandom));
                    put_crlf();
                end
            end
        end

        last_at = -1;
        if (wide) begin
            last_at = msg.size() - 1;
        end else if (kind == MSG_CUT) begin
            k   = $urandom_range(msg.size() - 2);
            msg = msg[0:k];
            if ($urandom_range(4) != 0) last_at = k;
        end else if ($urandom_range(9) < 7) begin
            last_at = msg.size() - 1;
        end
        useful = msg.size();
        // Trailing bytes after the body ends or halts are dropped by the parser
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
        send_msg(last_at);
    endtask

    // Driver
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else if (!in_valid || in_ready) begin
            if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
                in_valid <= 1'b1;
                in_data  <= pending_bytes.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check the result transaction, then predict from the input one
    always @(posedge clk) begin
        cbd_pkg::t_out_item want;
        cbd_pkg::t_out_item res;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= 37);
            if (out_valid && out_ready) begin
                if (out_res.has_byte) n_payload++;
                if (out_res.event_res == cbd_pkg::EV_DONE) n_done++;
                else if (out_res.event_res != cbd_pkg::EV_NONE) n_fault++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %p", out_res));
                end else begin
                    want = expected_results.pop_front();
                    if (out_res.has_byte !== want.has_byte)
                        report_mismatch($sformatf("has_byte got %0b want %0b",
                                                  out_res.has_byte, want.has_byte));
                    if (out_res.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                                  out_res.out_byte, want.out_byte));
                    if (out_res.event_res !== want.event_res)
                        report_mismatch($sformatf("event_res got %0d want %0d",
                                                  out_res.event_res, want.event_res));
                end
            end
            if (in_valid && in_ready) begin
                n_bytes++;
                if (decode_byte(in_data, res)) expected_results.push_back(res);
            end
        end
    end

    initial begin
        int useful_total;
        int n;
        useful_total = 0;

        // One complete body with a 0xFF payload byte
        msg = '{8'h31, cbd_pkg::CH_CR, cbd_pkg::CH_LF, 8'hFF, cbd_pkg::CH_CR,
                cbd_pkg::CH_LF, cbd_pkg::CH_0, cbd_pkg::CH_CR, cbd_pkg::CH_LF};
        send_msg(msg.size() - 1);
        // Non-hex byte on a size line
        msg = '{cbd_pkg::CH_LO_F, 8'h00};
        send_msg(-1);
        // CR not followed by LF
        msg = '{cbd_pkg::CH_UP_F, cbd_pkg::CH_CR, 8'h78};
        send_msg(-1);
        // One digit too many
        msg = '{cbd_pkg::CH_9, cbd_pkg::CH_LO_A, cbd_pkg::CH_UP_F, cbd_pkg::CH_0,
                cbd_pkg::CH_LO_F, cbd_pkg::CH_UP_A, 8'h31, 8'h32, 8'h33};
        send_msg(msg.size() - 1);
        // Input ends on a payload byte
        msg = '{8'h32, cbd_pkg::CH_CR, cbd_pkg::CH_LF, 8'h00};
        send_msg(msg.size() - 1);

        while (useful_total < 650) begin
            build_message(n);
            useful_total += n;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        do @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (16) @(negedge clk);

        $display("Sent %0d bytes in %0d messages; checked %0d payload bytes,",
                 n_bytes, n_msgs, n_payload);
        $display("%0d completed bodies and %0d error events.", n_done, n_fault);
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d results still expected", expected_results.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
